FILE: rtl/ows_pkg.sv
// ============================================================================
// ows_pkg: shared types and constants of the 1-Wire search-ROM engine
// Holds the command and status codes, the item and result records, and
// the bit-serial reflected CRC-8 step used by the decision core.
// ============================================================================
package ows_pkg;

    localparam int unsigned ROM_BITS = 64;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned CRC_W    = 8;

    localparam logic [CRC_W-1:0] CRC_POLY  = 8'h8c;
    localparam logic [POS_W-1:0] FIRST_POS = 7'd1;
    localparam logic [POS_W-1:0] LAST_POS  = 7'd64;
    localparam logic [POS_W-1:0] DONE_POS  = 7'd65;

    typedef enum logic [1:0] {
        CMD_FIRST    = 2'd0,
        CMD_NEXT     = 2'd1,
        CMD_BIT_PAIR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RUNNING     = 3'd0,
        ST_OK          = 3'd1,
        ST_NO_DEVICES  = 3'd2,
        ST_LAST_DEVICE = 3'd3,
        ST_CRC_FAIL    = 3'd4,
        ST_FAMILY_ZERO = 3'd5,
        ST_IDLE        = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0] command;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } item_t;

    typedef struct packed {
        logic                direction_bit;
        logic                finished;
        status_t             status;
        logic [ROM_BITS-1:0] rom_code;
    } result_t;

    // One step of the reflected CRC-8, fed one data bit.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic             data);
        logic [CRC_W-1:0] shifted;
        shifted = {1'b0, crc[CRC_W-1:1]};
        if (crc[0] ^ data)
        begin
            shifted = shifted ^ CRC_POLY;
        end
        return shifted;
    endfunction

endpackage

FILE: rtl/ows_core.sv
// ============================================================================
// ows_core: search state and per-item decision logic
// Keeps the ROM code, fork positions, bit position and CRC, and turns one
// item into its result and the next search state combinationally.
// ============================================================================
module ows_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ows_pkg::item_t   item,
    output ows_pkg::result_t result
);

    logic [ows_pkg::ROM_BITS-1:0] rom_reg, rom_next;
    logic [ows_pkg::POS_W-1:0]    last_fork_reg, last_fork_next;
    logic                         last_seen_reg, last_seen_next;
    logic                         searching_reg, searching_next;
    logic [ows_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [ows_pkg::POS_W-1:0]    zero_fork_reg, zero_fork_next;
    logic [ows_pkg::CRC_W-1:0]    crc_reg, crc_next;

    logic [ows_pkg::IDX_W-1:0]    idx;
    logic [ows_pkg::POS_W-1:0]    pos_dec;
    logic                         dir;
    logic                         fin;
    logic                         seen;
    ows_pkg::status_t             status;

    assign pos_dec = pos_reg - ows_pkg::FIRST_POS;
    assign idx     = pos_dec[ows_pkg::IDX_W-1:0];

    always_comb
    begin
        rom_next       = rom_reg;
        last_fork_next = last_fork_reg;
        last_seen_next = last_seen_reg;
        searching_next = searching_reg;
        pos_next       = pos_reg;
        zero_fork_next = zero_fork_reg;
        crc_next       = crc_reg;
        dir            = 1'b0;
        fin            = 1'b0;
        seen           = last_seen_reg;
        status         = searching_reg ? ows_pkg::ST_RUNNING : ows_pkg::ST_IDLE;

        case (item.command)
            ows_pkg::CMD_FIRST, ows_pkg::CMD_NEXT:
            begin
                if (item.command == ows_pkg::CMD_FIRST)
                begin
                    last_fork_next = '0;
                    last_seen_next = 1'b0;
                    seen           = 1'b0;
                end
                if (seen)
                begin
                    searching_next = 1'b0;
                    fin            = 1'b1;
                    status         = ows_pkg::ST_LAST_DEVICE;
                end
                else if (!item.presence)
                begin
                    searching_next = 1'b0;
                    fin            = 1'b1;
                    status         = ows_pkg::ST_NO_DEVICES;
                end
                else
                begin
                    searching_next = 1'b1;
                    pos_next       = ows_pkg::FIRST_POS;
                    zero_fork_next = '0;
                    crc_next       = '0;
                    status         = ows_pkg::ST_RUNNING;
                end
            end
            ows_pkg::CMD_BIT_PAIR:
            begin
                if (!searching_reg)
                begin
                    status = ows_pkg::ST_IDLE;
                end
                else if (item.id_bit && item.complement_bit)
                begin
                    searching_next = 1'b0;
                    fin            = 1'b1;
                    status         = ows_pkg::ST_NO_DEVICES;
                end
                else
                begin
                    if (item.id_bit != item.complement_bit)
                    begin
                        dir = item.id_bit;
                    end
                    else
                    begin
                        // Discrepancy: repeat the earlier path below the last
                        // fork, take 1 at it, and 0 beyond it.
                        if (pos_reg < last_fork_reg)
                        begin
                            dir = rom_reg[idx];
                        end
                        else
                        begin
                            dir = (pos_reg == last_fork_reg);
                        end
                        if (!dir)
                        begin
                            zero_fork_next = pos_reg;
                        end
                    end
                    rom_next[idx] = dir;
                    crc_next      = ows_pkg::crc_step(crc_reg, dir);
                    if (pos_reg >= ows_pkg::LAST_POS)
                    begin
                        searching_next = 1'b0;
                        pos_next       = ows_pkg::DONE_POS;
                        fin            = 1'b1;
                        if (crc_next != '0)
                        begin
                            status = ows_pkg::ST_CRC_FAIL;
                        end
                        else if (rom_next[7:0] == 8'h00)
                        begin
                            status = ows_pkg::ST_FAMILY_ZERO;
                        end
                        else
                        begin
                            last_fork_next = zero_fork_next;
                            last_seen_next = (zero_fork_next == '0);
                            status         = ows_pkg::ST_OK;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + ows_pkg::FIRST_POS;
                        status   = ows_pkg::ST_RUNNING;
                    end
                end
            end
            default:
            begin
                status = searching_reg ? ows_pkg::ST_RUNNING : ows_pkg::ST_IDLE;
            end
        endcase

        result.direction_bit = dir;
        result.finished      = fin;
        result.status        = status;
        result.rom_code      = rom_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_fork_reg <= '0;
            last_seen_reg <= 1'b0;
            searching_reg <= 1'b0;
            pos_reg       <= ows_pkg::FIRST_POS;
            zero_fork_reg <= '0;
            crc_reg       <= '0;
        end
        else if (step)
        begin
            rom_reg       <= rom_next;
            last_fork_reg <= last_fork_next;
            last_seen_reg <= last_seen_next;
            searching_reg <= searching_next;
            pos_reg       <= pos_next;
            zero_fork_reg <= zero_fork_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

FILE: rtl/onewire_rom_search.sv
// ============================================================================
// onewire_rom_search: 1-Wire search-ROM decision engine, top level
// Input register, combinational decision core and result register.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) carries one item per transfer: a
// start command (first or next search) with the presence flag of the bus
// reset, or a bit pair read from the bus. Every item yields exactly one
// result on the output channel (out_valid/out_ready): the direction bit to
// write back, a finished flag, a status code and the ROM code as it stands
// after the item.
// An accepted item is held in the input register, and its result is
// captured in the result register, which drives out_valid. Throughput is
// one item per cycle while the receiver is ready; the only work per item
// is the fork decision, one step of the serial CRC-8 and the end-of-pass
// checks, all between the input register and the result register.
// Reset clears the search state: no pass running, bit position one, ROM,
// forks and CRC zero, and both pipeline registers empty.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item, after which in_ready drops
// until the result is taken.
// ============================================================================
module onewire_rom_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        presence,
    input  logic        id_bit,
    input  logic        complement_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        direction_bit,
    output logic        finished,
    output logic [2:0]  status,
    output logic [63:0] rom_code
);

    logic             in_valid_reg;
    ows_pkg::item_t   item_reg;
    logic             out_valid_reg;
    ows_pkg::result_t result_reg;
    ows_pkg::result_t core_result;
    logic             advance;

    // The held item moves into the result register whenever that register
    // is empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.command        <= command;
            item_reg.presence       <= presence;
            item_reg.id_bit         <= id_bit;
            item_reg.complement_bit <= complement_bit;
        end
    end

    // The core commits its state only on the cycle its result is captured.
    ows_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign direction_bit = result_reg.direction_bit;
    assign finished      = result_reg.finished;
    assign status        = 3'(result_reg.status);
    assign rom_code      = result_reg.rom_code;

endmodule

FILE: rtl/ows_checker.sv
// ============================================================================
// ows_checker: port-level checks for the search-ROM engine
// Watches the result channel for held results and consistent status flags.
// ============================================================================
module ows_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        direction_bit,
    input logic        finished,
    input logic [2:0]  status,
    input logic [63:0] rom_code
);

    // A stalled result keeps its status and ROM code.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(rom_code))
        else $error("stalled result changed");

    // A finished result carries a final status.
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |->
            status != 3'(ows_pkg::ST_RUNNING) && status != 3'(ows_pkg::ST_IDLE))
        else $error("finished result with running or idle status");

    // An unfinished result is either running or idle.
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |->
            status == 3'(ows_pkg::ST_RUNNING) || status == 3'(ows_pkg::ST_IDLE))
        else $error("unfinished result with final status");

    // A one is written back only for a bit that was actually decided.
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direction_bit |->
            status != 3'(ows_pkg::ST_IDLE) && status != 3'(ows_pkg::ST_NO_DEVICES)
            && status != 3'(ows_pkg::ST_LAST_DEVICE))
        else $error("direction bit set without a decided bit");

endmodule

bind onewire_rom_search ows_checker u_ows_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .direction_bit (direction_bit),
    .finished      (finished),
    .status        (status),
    .rom_code      (rom_code)
);
